// ===== sv/plh_pkg.sv =====
// ----------------------------------------------------------------------------
// plh_pkg
// Shared types, sizes and helpers for the per-key log2 histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package plh_pkg;

    // table sizes
    localparam int NUM_KEYS = 1024;
    localparam int NUM_BINS = 15;

    // field widths
    localparam int ID_W    = 32;
    localparam int CNT_W   = 64;
    localparam int BCNT_W  = 32;
    localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int USED_W  = KEY_W + 1;
    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int CTR_DEPTH = NUM_KEYS * NUM_BINS;
    localparam int CTR_AW  = $clog2(CTR_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID     = 2'd1;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        STAT_COUNTED  = 2'd0,
        STAT_NEGATIVE = 2'd1,
        STAT_FILTERED = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_CLEAR,
        BK_READ,
        BK_UPDATE
    } back_state_t;

    // classified item handed from front to back
    typedef struct packed {
        status_t             kind;
        logic [ID_W-1:0]     id;
        logic [BIN_W-1:0]    bin;
    } item_t;

    // one result toward the output ports
    typedef struct packed {
        logic                done;
        status_t             status;
        logic [KEY_W-1:0]    entry;
        logic [BIN_W-1:0]    bin;
        logic [BCNT_W-1:0]   count;
    } result_t;

    // floor(log2(v)) clamped to the last bin; zero goes to bin 0
    function automatic logic [BIN_W-1:0] bin_of(input logic [CNT_W-1:0] v);
        logic [BIN_W-1:0] r;
        r = '0;
        if ((v >> (NUM_BINS - 1)) != '0) begin
            r = BIN_W'(NUM_BINS - 1);
        end
        else begin
            for (int i = 1; i < NUM_BINS - 1; i++) begin
                if (v[i]) begin
                    r = BIN_W'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/plh_ram.sv =====
// ----------------------------------------------------------------------------
// plh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module plh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/plh_front.sv =====
// ----------------------------------------------------------------------------
// plh_front
// Configuration registers and item classification: sign test, id filter and
// log2 bin, ahead of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plh_front import plh_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    input  wire logic [ID_W-1:0]       process_id,
    input  wire logic [CNT_W-1:0]      byte_count,
    input  wire logic                  q_full,
    output logic                       busy,
    output logic                       q_push,
    output item_t                      q_item
);

    logic            filter_enable_reg;
    logic [ID_W-1:0] target_id_reg;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            target_id_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                CFG_TARGET_ID:     target_id_reg     <= cfg_data[ID_W-1:0];
                default:           ;
            endcase
        end
    end

    // accept while the queue has room
    assign busy   = q_full;
    assign q_push = start && !q_full;

    // classify: negative first, then filter
    always_comb
    begin
        q_item.id  = process_id;
        q_item.bin = bin_of(byte_count);
        if (byte_count[CNT_W-1])
        begin
            q_item.kind = STAT_NEGATIVE;
        end
        else if (filter_enable_reg && (process_id != target_id_reg))
        begin
            q_item.kind = STAT_FILTERED;
        end
        else
        begin
            q_item.kind = STAT_COUNTED;
        end
    end

endmodule

`default_nettype wire

// ===== sv/plh_queue.sv =====
// ----------------------------------------------------------------------------
// plh_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module plh_queue import plh_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       full,
    output logic       empty
);

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign full     = (fill_reg == QCNT_W'(QDEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'((int'(wr_ptr_reg) + 1) % QDEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'((int'(rd_ptr_reg) + 1) % QDEPTH);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/plh_back.sv =====
// ----------------------------------------------------------------------------
// plh_back
// Executes queued items: key scan, new-key allocation with bin clearing,
// and read-modify-write of one bin counter for counted items.
// ----------------------------------------------------------------------------
`default_nettype none

module plh_back import plh_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire item_t q_item,
    output logic       q_pop,
    output result_t    res
);

    back_state_t       state_reg,    state_next;
    item_t             item_reg,     item_next;
    logic [USED_W-1:0] used_reg,     used_next;
    logic [USED_W-1:0] scan_reg,     scan_next;
    logic              cmp_vld_reg,  cmp_vld_next;
    logic [KEY_W-1:0]  cmp_idx_reg,  cmp_idx_next;
    logic [KEY_W-1:0]  entry_reg,    entry_next;
    logic [BIN_W-1:0]  clr_bin_reg,  clr_bin_next;
    result_t           res_reg,      res_next;

    // key RAM ports
    logic              key_we;
    logic [KEY_W-1:0]  key_waddr;
    logic [KEY_W-1:0]  key_raddr;
    logic [ID_W-1:0]   key_rdata;

    // counter RAM ports
    logic              ctr_we;
    logic [CTR_AW-1:0] ctr_waddr;
    logic [BCNT_W-1:0] ctr_wdata;
    logic [CTR_AW-1:0] ctr_raddr;
    logic [BCNT_W-1:0] ctr_rdata;

    logic [CTR_AW-1:0] base;
    logic [BCNT_W-1:0] ctr_inc;

    plh_ram #(.WIDTH(ID_W), .DEPTH(NUM_KEYS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (item_reg.id),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    plh_ram #(.WIDTH(BCNT_W), .DEPTH(CTR_DEPTH)) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // first counter of the current entry, and the updated count
    assign base    = CTR_AW'(entry_reg) * CTR_AW'(NUM_BINS);
    assign ctr_inc = ctr_rdata + 1'b1;
    assign res     = res_reg;

    // control registers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            used_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            cmp_vld_reg  <= cmp_vld_next;
            res_reg      <= res_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        entry_reg      <= entry_next;
        clr_bin_reg    <= clr_bin_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        used_next    = used_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        entry_next   = entry_reg;
        clr_bin_next = clr_bin_reg;
        res_next     = '0;
        q_pop        = 1'b0;
        key_we       = 1'b0;
        key_waddr    = used_reg[KEY_W-1:0];
        key_raddr    = scan_reg[KEY_W-1:0];
        ctr_we       = 1'b0;
        ctr_waddr    = base + CTR_AW'(clr_bin_reg);
        ctr_wdata    = '0;
        ctr_raddr    = base + CTR_AW'(item_reg.bin);

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.kind == STAT_COUNTED)
                    begin
                        scan_next  = '0;
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = q_item.kind;
                    end
                end
            end

            // one key read per cycle, compared in the following cycle
            BK_SCAN:
            begin
                if (cmp_vld_reg && (key_rdata == item_reg.id))
                begin
                    entry_next = cmp_idx_reg;
                    state_next = BK_READ;
                end
                else if (scan_reg < used_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[KEY_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else if (cmp_vld_reg)
                begin
                    // last compare missed; settle next cycle
                    cmp_vld_next = 1'b0;
                end
                else if (used_reg == USED_W'(NUM_KEYS))
                begin
                    res_next.done   = 1'b1;
                    res_next.status = STAT_FULL;
                    state_next      = BK_IDLE;
                end
                else
                begin
                    // new key takes the next free entry
                    key_we       = 1'b1;
                    entry_next   = used_reg[KEY_W-1:0];
                    used_next    = used_reg + 1'b1;
                    clr_bin_next = '0;
                    state_next   = BK_CLEAR;
                end
            end

            // zero the new entry's bins
            BK_CLEAR:
            begin
                ctr_we       = 1'b1;
                clr_bin_next = clr_bin_reg + 1'b1;
                if (clr_bin_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = BK_READ;
                end
            end

            BK_READ:
            begin
                state_next = BK_UPDATE;
            end

            // write back the incremented counter and report it
            BK_UPDATE:
            begin
                ctr_we          = 1'b1;
                ctr_waddr       = ctr_raddr;
                ctr_wdata       = ctr_inc;
                res_next.done   = 1'b1;
                res_next.status = STAT_COUNTED;
                res_next.entry  = entry_reg;
                res_next.bin    = item_reg.bin;
                res_next.count  = ctr_inc;
                state_next      = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/per_key_log2_histogram.sv =====
// ----------------------------------------------------------------------------
// per_key_log2_histogram
// Per-key log2 histogram of signed byte counts with a key table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only while
// the two-entry item queue is full. Every item yields one result, shown for
// exactly one cycle with done high, in input order; it must be captured then.
// A negative or filtered item is reported from the back end's idle state. A
// counted item runs a key scan, which reads one stored key per cycle from the
// key RAM; an item that brings a new key also zeroes all NUM_BINS counters of
// that entry through the counter RAM write port. Counters of an entry are
// cleared when the entry is allocated, so no clearing pass follows reset.
// Configuration writes must go in only while idle; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module per_key_log2_histogram import plh_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ID_W-1:0]       process_id,
    input  wire logic signed [CNT_W-1:0] byte_count,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [KEY_W-1:0]           entry_index,
    output logic [BIN_W-1:0]           bin,
    output logic [BCNT_W-1:0]          bin_count
);

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    item_t   push_item;
    item_t   pop_item;
    result_t res;

    plh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .process_id (process_id),
        .byte_count (byte_count),
        .q_full     (q_full),
        .busy       (busy),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    plh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    plh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .res     (res)
    );

    // result ports
    assign done        = res.done;
    assign status      = res.status;
    assign entry_index = res.entry;
    assign bin         = res.bin;
    assign bin_count   = res.count;

endmodule

`default_nettype wire

// ===== bench/per_key_log2_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// per_key_log2_histogram_tb
// Self-checking bench for the per-key log2 histogram. Events are sent through
// the start/busy handshake and each done strobe is compared field by field
// against an in-bench histogram predictor. Coverage comes from a directed
// pass over bin edges, sign and filter order, a long random pass with changing
// filter settings and sender gaps, and a pass that fills the key table.
// ----------------------------------------------------------------------------

module per_key_log2_histogram_tb;

    import plh_pkg::*;

    // run limit in cycles; a full-table scan reads every stored key for each
    // item, so this leaves several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int          POOL_SIZE   = 48;

    // register indexes past the list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        status_t            st;
        logic [KEY_W-1:0]   entry;
        logic [BIN_W-1:0]   bin_no;
        logic [BCNT_W-1:0]  count;
    } hist_result_t;

    // DUT ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [ID_W-1:0]         process_id = '0;
    logic signed [CNT_W-1:0] byte_count = '0;
    logic                    done;
    logic [1:0]              status;
    logic [KEY_W-1:0]        entry_index;
    logic [BIN_W-1:0]        bin;
    logic [BCNT_W-1:0]       bin_count;

    // predictor state
    bit [ID_W-1:0]      key_ids [NUM_KEYS];
    int unsigned        entry_of [bit [ID_W-1:0]];
    int unsigned        table_fill = 0;
    logic [BCNT_W-1:0]  bin_counts [NUM_KEYS*NUM_BINS];
    logic               filt_on = 1'b0;
    logic [ID_W-1:0]    filt_id = '0;

    hist_result_t       pending_results [$];
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;
    int                 idle_pct = 0;
    logic [ID_W-1:0]    id_pool [POOL_SIZE];

    per_key_log2_histogram dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .process_id  (process_id),
        .byte_count  (byte_count),
        .done        (done),
        .status      (status),
        .entry_index (entry_index),
        .bin         (bin),
        .bin_count   (bin_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // floor(log2(v)), zero in bin 0, clamped to the top bin
    function automatic logic [BIN_W-1:0] count_bin(input logic [CNT_W-1:0] v);
        int top;
        top = 0;
        for (int i = 1; i < CNT_W; i++)
        begin
            if (v[i])
                top = i;
        end
        if (top > NUM_BINS - 1)
            top = NUM_BINS - 1;
        return BIN_W'(top);
    endfunction

    // histogram update for one accepted event; returns the expected result
    function automatic hist_result_t predict_event(input logic [ID_W-1:0] pid,
                                                   input logic [CNT_W-1:0] cnt);
        hist_result_t r;
        int unsigned  slot;
        int unsigned  k;
        r = '0;
        r.st = STAT_COUNTED;
        if (cnt[CNT_W-1])
            r.st = STAT_NEGATIVE;
        else if (filt_on && pid != filt_id)
            r.st = STAT_FILTERED;
        else if (!entry_of.exists(pid) && table_fill >= NUM_KEYS)
            r.st = STAT_FULL;
        else
        begin
            // new key: next free entry, bins start cleared
            if (!entry_of.exists(pid))
            begin
                entry_of[pid] = table_fill;
                key_ids[table_fill] = pid;
                for (k = 0; k < NUM_BINS; k++)
                    bin_counts[table_fill*NUM_BINS + k] = '0;
                table_fill++;
            end
            slot = entry_of[pid];
            r.bin_no = count_bin(cnt);
            k = slot*NUM_BINS + r.bin_no;
            bin_counts[k] = bin_counts[k] + 1'b1;
            r.entry = KEY_W'(slot);
            r.count = bin_counts[k];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // result checker: every done strobe against the oldest expectation
    always @(posedge clk)
    begin : check_results
        hist_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item pending", 64'(status), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (entry_index !== want.entry)
                    report_mismatch("entry_index", 64'(entry_index), 64'(want.entry));
                if (bin !== want.bin_no)
                    report_mismatch("bin", 64'(bin), 64'(want.bin_no));
                if (bin_count !== want.count)
                    report_mismatch("bin_count", 64'(bin_count), 64'(want.count));
            end
        end
    end

    // send one item; start stays high on return so back-to-back items flow
    task automatic send_event(input logic [ID_W-1:0] pid, input logic [CNT_W-1:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        process_id <= pid;
        byte_count <= cnt;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_event(pid, cnt));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_FILTER_ENABLE: filt_on = data[0];
            CFG_TARGET_ID:     filt_id = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // non-negative size with a random magnitude, zero included
    function automatic logic [CNT_W-1:0] rand_size();
        logic [CNT_W-1:0] v;
        v = {$urandom, $urandom} >> $urandom_range(64);
        v[CNT_W-1] = 1'b0;
        return v;
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] pid;
        do
            pid = $urandom;
        while (entry_of.exists(pid));
        return pid;
    endfunction

    // bin edges, sign handling, filter order, spare register indexes
    task automatic test_directed();
        logic [ID_W-1:0] id_a;
        id_a = 32'h1234_5678;
        idle_pct = 6;
        write_reg(CFG_FILTER_ENABLE, '0);
        write_reg(CFG_TARGET_ID, '0);

        send_event(id_a, 64'd0);
        send_event(id_a, 64'd1);
        send_event(id_a, 64'd2);
        send_event(id_a, 64'd3);
        send_event(id_a, 64'd1 << 13);
        send_event(id_a, (64'd1 << 14) - 1);
        send_event(id_a, 64'd1 << 14);
        send_event(id_a, 64'h7FFF_FFFF_FFFF_FFFF);
        send_event(id_a, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(id_a, 64'h8000_0000_0000_0000);
        send_event(32'h0000_0000, 64'd5);
        send_event(32'hFFFF_FFFF, 64'd1 << 32);

        // filter on; negative test must win over the filter
        wait_drained();
        write_reg(CFG_TARGET_ID, 32'hFFFF_FFFF);
        write_reg(CFG_FILTER_ENABLE, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        send_event(32'hFFFF_FFFF, 64'd7);
        send_event(32'h0000_0000, 64'd5);
        send_event(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
        send_event(32'hFFFF_FFFE, 64'd100);

        // only bit 0 of the enable counts
        wait_drained();
        write_reg(CFG_FILTER_ENABLE, 32'hFFFF_FFFE);
        write_reg(CFG_TARGET_ID, '0);
        send_event(32'h0000_0000, 64'd1 << 20);
        send_event(32'h8000_0000, 64'h0000_0000_0000_4000);
        send_event(id_a, 64'd1 << 62);
        wait_drained();
    endtask

    task automatic send_random_event();
        logic [ID_W-1:0]  pid;
        logic [CNT_W-1:0] cnt;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 70)
            pid = id_pool[$urandom_range(POOL_SIZE-1)];
        else if (pick < 84)
            pid = filt_id;
        else if (pick < 90)
            pid = $urandom;
        else
            pid = key_ids[$urandom_range(table_fill-1)];
        if ($urandom_range(99) < 15)
            cnt = {1'b1, 31'($urandom), $urandom};
        else
            cnt = rand_size();
        send_event(pid, cnt);
    endtask

    // random events in three gap regimes, re-filtered between blocks
    task automatic test_random();
        int gaps [3];
        gaps = '{6, 73, 0};
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = gaps[ph];
            for (int blk = 0; blk < 5; blk++)
            begin
                wait_drained();
                write_reg(CFG_FILTER_ENABLE,
                          {31'($urandom), 1'b0} | 32'($urandom_range(99) < 40));
                if ($urandom_range(1))
                    write_reg(CFG_TARGET_ID, id_pool[$urandom_range(POOL_SIZE-1)]);
                else
                    write_reg(CFG_TARGET_ID, $urandom);
                for (int n = 0; n < 38; n++)
                    send_random_event();
            end
        end
        wait_drained();
    endtask

    // fill every entry, then known keys still count and new ones drop
    task automatic test_full_table();
        logic [ID_W-1:0] pid;
        idle_pct = 0;
        wait_drained();
        write_reg(CFG_FILTER_ENABLE, '0);
        while (table_fill < NUM_KEYS)
            send_event(fresh_id(), rand_size());

        send_event(key_ids[NUM_KEYS-1], rand_size());
        send_event(key_ids[0], 64'h7FFF_FFFF_FFFF_FFFF);
        for (int n = 0; n < 6; n++)
            send_event(key_ids[$urandom_range(NUM_KEYS-1)], rand_size());
        for (int n = 0; n < 4; n++)
            send_event(fresh_id(), rand_size());
        send_event(fresh_id(), 64'hFFFF_FFFF_FFFF_FFFF);

        // filter targets an unknown key: dropped, others filtered
        wait_drained();
        pid = fresh_id();
        write_reg(CFG_TARGET_ID, pid);
        write_reg(CFG_FILTER_ENABLE, 32'd1);
        send_event(pid, 64'd3);
        send_event(key_ids[5], 64'd3);

        wait_drained();
        write_reg(CFG_TARGET_ID, key_ids[NUM_KEYS/2]);
        send_event(key_ids[NUM_KEYS/2], 64'd9);
        send_event(pid, 64'd9);
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_KEYS*NUM_BINS; i++)
            bin_counts[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_full_table();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
